[hw/rtl/rc5_tx_pkg.sv]
// ----------------------------------------------------------------------------
// rc5_tx_pkg
// Shared types and constants of the RC-5 style infrared frame transmitter:
// frame layout defaults, port and field widths, register indexes, register reset values, modes.
// ----------------------------------------------------------------------------
package rc5_tx_pkg;

  // Frame layout defaults
  localparam int DEF_ADDRESS_BITS = 5;
  localparam int DEF_COMMAND_BITS = 6;

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  // Register field widths
  localparam int PULSE_W = 8;
  localparam int SPACE_W = 12;
  localparam int TICK_W  = 18;
  localparam int ADDR_W  = 5;
  localparam int CODE_W  = 4;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CARRIER_HIGH = 3'd0,
    REG_CARRIER_LOW  = 3'd1,
    REG_PULSES_HALF  = 3'd2,
    REG_SPACE        = 3'd3,
    REG_FRAME_GAP    = 3'd4,
    REG_DEVICE_ADDR  = 3'd5
  } reg_index_t;

  // Register reset values
  localparam logic [PULSE_W-1:0] RST_CARRIER_HIGH = 8'd8;
  localparam logic [PULSE_W-1:0] RST_CARRIER_LOW  = 8'd19;
  localparam logic [PULSE_W-1:0] RST_PULSES_HALF  = 8'd31;
  localparam logic [SPACE_W-1:0] RST_SPACE        = 12'd810;
  localparam logic [TICK_W-1:0]  RST_FRAME_GAP    = 18'd114000;
  localparam logic [ADDR_W-1:0]  RST_DEVICE_ADDR  = 5'd9;

  // Transmitter modes
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_GAP  = 2'd2
  } mode_t;

endpackage

[hw/rtl/rc5_ir_frame_transmitter.sv]
// The result of an accepted item is in the output register in the next cycle.
// Throughput: one item per cycle while in_stall is low; the whole update of the frame
// sequencer (counters, bit pointer, carrier phase) sits between the state registers.
// An item is taken while a result waits, as long as the output register frees.
// Reset (rst, synchronous) returns to idle with toggle and previous code
// cleared and all timing registers at their default values.
// ----------------------------------------------------------------------------
// rc5_ir_frame_transmitter
// Builds RC-5 style frames from button samples and times the Manchester
// halves and carrier pulses from one-microsecond tick items.
// ----------------------------------------------------------------------------
module rc5_ir_frame_transmitter #(
  parameter int ADDRESS_BITS = rc5_tx_pkg::DEF_ADDRESS_BITS,
  parameter int COMMAND_BITS = rc5_tx_pkg::DEF_COMMAND_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [rc5_tx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rc5_tx_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [rc5_tx_pkg::CODE_W-1:0]      buttons,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               tx_level,
  output logic                               busy_res,
  output logic                               started
);
  import rc5_tx_pkg::*;

  localparam int FRAME_BITS = 3 + ADDRESS_BITS + COMMAND_BITS;
  localparam int IDX_W      = $clog2(FRAME_BITS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

  // Configuration registers
  logic [PULSE_W-1:0] carrier_high_ticks;
  logic [PULSE_W-1:0] carrier_low_ticks;
  logic [PULSE_W-1:0] pulses_per_half;
  logic [SPACE_W-1:0] space_ticks;
  logic [TICK_W-1:0]  frame_gap_ticks;
  logic [ADDR_W-1:0]  device_address;

  // Sequencer state
  mode_t                 mode, mode_next;
  logic                  toggle_bit, toggle_bit_next;
  logic [CODE_W-1:0]     previous_code, previous_code_next;
  logic [FRAME_BITS-1:0] frame_bits, frame_bits_next;
  logic [IDX_W-1:0]      bit_index, bit_index_next;
  logic                  half_phase, half_phase_next;
  logic [PULSE_W-1:0]    pulse_count, pulse_count_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic                  carrier_phase, carrier_phase_next;

  logic                  accept;
  logic                  burst;
  logic                  burst_next;
  logic [TICK_W-1:0]     tick_inc;
  logic [PULSE_W-1:0]    pulse_inc;
  logic [TICK_W-1:0]     seg_len;
  logic [PULSE_W-1:0]    pulse_len;
  logic [IDX_W-1:0]      bit_index_dec;
  logic                  level_next;
  logic                  started_next;

  // Transfer handshake: stall only while a result is held
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_high_ticks <= RST_CARRIER_HIGH;
      carrier_low_ticks  <= RST_CARRIER_LOW;
      pulses_per_half    <= RST_PULSES_HALF;
      space_ticks        <= RST_SPACE;
      frame_gap_ticks    <= RST_FRAME_GAP;
      device_address     <= RST_DEVICE_ADDR;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CARRIER_HIGH: carrier_high_ticks <= cfg_data[PULSE_W-1:0];
        REG_CARRIER_LOW:  carrier_low_ticks  <= cfg_data[PULSE_W-1:0];
        REG_PULSES_HALF:  pulses_per_half    <= cfg_data[PULSE_W-1:0];
        REG_SPACE:        space_ticks        <= cfg_data[SPACE_W-1:0];
        REG_FRAME_GAP:    frame_gap_ticks    <= cfg_data[TICK_W-1:0];
        REG_DEVICE_ADDR:  device_address     <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Current half: burst when bit is 0 in first half or 1 in second half
  assign burst         = half_phase ? frame_bits[bit_index] : !frame_bits[bit_index];
  assign tick_inc      = tick_count + TICK_W'(1);
  assign pulse_inc     = pulse_count + PULSE_W'(1);
  assign bit_index_dec = bit_index - IDX_W'(1);
  assign pulse_len     = (pulses_per_half == '0) ? PULSE_W'(1) : pulses_per_half;

  // Length of the running segment, zero lengths count as one tick
  always_comb begin
    if (!burst) begin
      seg_len = (space_ticks == '0) ? TICK_W'(1) : TICK_W'(space_ticks);
    end else if (carrier_phase) begin
      seg_len = (carrier_high_ticks == '0) ? TICK_W'(1) : TICK_W'(carrier_high_ticks);
    end else begin
      seg_len = (carrier_low_ticks == '0) ? TICK_W'(1) : TICK_W'(carrier_low_ticks);
    end
  end

  // Next state for one accepted item
  always_comb begin
    logic half_end;
    half_end = 1'b0;

    mode_next          = mode;
    toggle_bit_next    = toggle_bit;
    previous_code_next = previous_code;
    frame_bits_next    = frame_bits;
    bit_index_next     = bit_index;
    half_phase_next    = half_phase;
    pulse_count_next   = pulse_count;
    tick_count_next    = tick_count;
    carrier_phase_next = carrier_phase;
    started_next       = 1'b0;

    if (func) begin
      // Start a frame on a nonzero sample while idle
      if (mode != MODE_SEND && mode != MODE_GAP && buttons != '0) begin
        toggle_bit_next    = (buttons == previous_code) ? !toggle_bit : 1'b0;
        previous_code_next = buttons;
        frame_bits_next    = {2'b11, toggle_bit_next,
                              ADDRESS_BITS'(device_address), COMMAND_BITS'(buttons)};
        bit_index_next     = LAST_IDX;
        half_phase_next    = 1'b0;
        mode_next          = MODE_SEND;
        tick_count_next    = '0;
        pulse_count_next   = '0;
        carrier_phase_next = 1'b0;
        started_next       = 1'b1;
      end
    end else begin
      case (mode)
        MODE_SEND: begin
          tick_count_next = tick_inc;
          if (tick_inc >= seg_len) begin
            tick_count_next = '0;
            if (!burst) begin
              half_end = 1'b1;
            end else if (carrier_phase) begin
              carrier_phase_next = 1'b0;
            end else begin
              pulse_count_next = pulse_inc;
              if (pulse_inc >= pulse_len) begin
                half_end = 1'b1;
              end else begin
                carrier_phase_next = 1'b1;
              end
            end
          end
          // Advance to the next half, the next bit or the frame gap
          if (half_end) begin
            if (!half_phase) begin
              half_phase_next    = 1'b1;
              tick_count_next    = '0;
              pulse_count_next   = '0;
              carrier_phase_next = frame_bits[bit_index];
            end else if (bit_index == '0) begin
              tick_count_next    = '0;
              carrier_phase_next = 1'b0;
              half_phase_next    = 1'b0;
              mode_next          = (frame_gap_ticks == '0) ? MODE_IDLE : MODE_GAP;
            end else begin
              bit_index_next     = bit_index_dec;
              half_phase_next    = 1'b0;
              tick_count_next    = '0;
              pulse_count_next   = '0;
              carrier_phase_next = !frame_bits[bit_index_dec];
            end
          end
        end
        MODE_GAP: begin
          tick_count_next = tick_inc;
          if (tick_inc >= frame_gap_ticks) begin
            tick_count_next = '0;
            mode_next       = MODE_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Emitter level after the update
  assign burst_next = half_phase_next ? frame_bits_next[bit_index_next]
                                      : !frame_bits_next[bit_index_next];
  assign level_next = (mode_next == MODE_SEND) && burst_next && carrier_phase_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      toggle_bit    <= 1'b0;
      previous_code <= '0;
      frame_bits    <= '0;
      bit_index     <= '0;
      half_phase    <= 1'b0;
      pulse_count   <= '0;
      tick_count    <= '0;
      carrier_phase <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      toggle_bit    <= toggle_bit_next;
      previous_code <= previous_code_next;
      frame_bits    <= frame_bits_next;
      bit_index     <= bit_index_next;
      half_phase    <= half_phase_next;
      pulse_count   <= pulse_count_next;
      tick_count    <= tick_count_next;
      carrier_phase <= carrier_phase_next;
    end
  end

  // Output register: load on accept, drop valid once the result transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_level <= level_next;
      busy_res <= (mode_next == MODE_SEND) || (mode_next == MODE_GAP);
      started  <= started_next;
    end
  end

endmodule
